/* src/swbrm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window byte rate meter: shared package
// Microcode program, control word layout and the divider control struct.
// ----------------------------------------------------------------------------
package swbrm_pkg;

  // Kind of an input word.
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Bit-serial divider iteration count.
  localparam int unsigned    DIV_CNT_W = 7;
  localparam logic [6:0]     DIV_ITERS = 7'd64;

  typedef struct packed {
    logic start;  // load operands and begin
  } div_ctl_t;

  // Microprogram addresses.
  typedef enum logic [3:0] {
    S_IDLE  = 4'd0,
    S_BR    = 4'd1,
    S_ACHK  = 4'd2,
    S_ASET  = 4'd3,
    S_CLR   = 4'd4,
    S_RD    = 4'd5,
    S_WR    = 4'd6,
    S_QWIN  = 4'd7,
    S_QSET  = 4'd8,
    S_SUM   = 4'd9,
    S_DIV   = 4'd10,
    S_DIVW  = 4'd11,
    S_EMIT  = 4'd12
  } step_e;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_LOAD     = 4'd0,
    OP_NOP      = 4'd1,
    OP_ADD_CHK  = 4'd2,
    OP_ADD_SET  = 4'd3,
    OP_CLEAR    = 4'd4,
    OP_RD_CUR   = 4'd5,
    OP_WR_CUR   = 4'd6,
    OP_Q_WIN    = 4'd7,
    OP_Q_SET    = 4'd8,
    OP_SUM      = 4'd9,
    OP_DIV_GO   = 4'd10,
    OP_DIV_TAKE = 4'd11,
    OP_EMIT     = 4'd12
  } op_e;

  // Jump conditions.
  typedef enum logic [2:0] {
    JC_NONE     = 3'd0,
    JC_NO_IN    = 3'd1,
    JC_DIV_BUSY = 3'd2,
    JC_QUERY    = 3'd3,
    JC_CNT_NZ   = 3'd4,
    JC_EMPTY    = 3'd5,
    JC_OUT_FULL = 3'd6
  } jc_e;

  typedef struct packed {
    op_e   op;
    jc_e   jc;
    step_e jt;  // taken when the condition holds
    step_e nx;  // taken otherwise
  } ucode_t;

  // The control store.
  function automatic ucode_t ucode(step_e s);
    ucode_t w;
    w = '{op: OP_LOAD, jc: JC_NO_IN, jt: S_IDLE, nx: S_BR};
    unique case (s)
      S_IDLE: w = '{op: OP_LOAD,     jc: JC_NO_IN,    jt: S_IDLE, nx: S_BR};
      S_BR:   w = '{op: OP_NOP,      jc: JC_QUERY,    jt: S_QWIN, nx: S_ACHK};
      S_ACHK: w = '{op: OP_ADD_CHK,  jc: JC_NONE,     jt: S_ASET, nx: S_ASET};
      S_ASET: w = '{op: OP_ADD_SET,  jc: JC_NONE,     jt: S_CLR,  nx: S_CLR};
      S_CLR:  w = '{op: OP_CLEAR,    jc: JC_CNT_NZ,   jt: S_CLR,  nx: S_RD};
      S_RD:   w = '{op: OP_RD_CUR,   jc: JC_NONE,     jt: S_WR,   nx: S_WR};
      S_WR:   w = '{op: OP_WR_CUR,   jc: JC_NONE,     jt: S_IDLE, nx: S_IDLE};
      S_QWIN: w = '{op: OP_Q_WIN,    jc: JC_NONE,     jt: S_QSET, nx: S_QSET};
      S_QSET: w = '{op: OP_Q_SET,    jc: JC_EMPTY,    jt: S_EMIT, nx: S_SUM};
      S_SUM:  w = '{op: OP_SUM,      jc: JC_CNT_NZ,   jt: S_SUM,  nx: S_DIV};
      S_DIV:  w = '{op: OP_DIV_GO,   jc: JC_NONE,     jt: S_DIVW, nx: S_DIVW};
      S_DIVW: w = '{op: OP_DIV_TAKE, jc: JC_DIV_BUSY, jt: S_DIVW, nx: S_EMIT};
      S_EMIT: w = '{op: OP_EMIT,     jc: JC_OUT_FULL, jt: S_EMIT, nx: S_IDLE};
      default: w = '{op: OP_NOP,     jc: JC_NONE,     jt: S_IDLE, nx: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* src/swbrm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window byte rate meter: channel interfaces
// Request channel (add or query word) and response channel (rate word).
// ----------------------------------------------------------------------------
interface swbrm_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] time_s;
  logic [31:0] byte_count;

  modport source (output valid, output kind, output time_s, output byte_count,
                  input ready);
  modport sink   (input valid, input kind, input time_s, input byte_count,
                  output ready);
endinterface

interface swbrm_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] rate_bps;
  logic [63:0] total_bytes;

  modport source (output valid, output rate_bps, output total_bytes, input ready);
  modport sink   (input valid, input rate_bps, input total_bytes, output ready);
endinterface

/* src/swbrm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window byte rate meter: bit-serial divider
// Restoring division, one quotient bit per cycle, 64 iterations.
// ----------------------------------------------------------------------------
module swbrm_div
  import swbrm_pkg::*;
#(
  parameter int unsigned DW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  div_ctl_t      ctl_i,
  input  logic [63:0]   dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          busy_o,
  output logic [63:0]   quotient_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [63:0]          dvd_q;
  logic [DW-1:0]        rem_q;
  logic [DW-1:0]        dsr_q;
  logic [DW:0]          trial;
  logic [DW:0]          diff;
  logic                 ge;

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = dvd_q;

  always_comb begin
    trial = {rem_q, dvd_q[63]};
    diff  = trial - {1'b0, dsr_q};
    ge    = (trial >= {1'b0, dsr_q});
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.start) begin
      cnt_d = DIV_ITERS;
    end else if (busy_o) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_o) begin
      dvd_q <= {dvd_q[62:0], ge};
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (rem_q < dsr_q))
    else $error("divider remainder reached the divisor");

  a_start_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |=> (busy_o && (rem_q == '0)))
    else $error("divider did not start cleanly");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DIV_ITERS)
    else $error("divider iteration count out of range");
`endif

endmodule

/* src/sliding_window_byte_rate_meter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window byte rate meter
// Per-second byte buckets in a ring, averaged over a sliding window.
// ----------------------------------------------------------------------------
// The meter takes one request word at a time. An add word books byte_count
// into the bucket of second time_s, clearing skipped seconds or restarting
// the window when time jumps back or leaps past the window; it gives no
// response. A query word returns the truncated mean bytes per second over
// the valid buckets of the window that ends at time_s (zero when there are
// none) together with the 64-bit running byte total. The bucket of a second
// sits at that second modulo the ring depth, the smallest power of two that
// holds the window, so the index is simply the low bits of time_s. Each word
// runs a short microprogram: an add clears the skipped seconds in turn before
// it books the bytes, and a query whose window holds valid seconds sums its
// buckets one by one and then runs the bit-serial division of the window
// sum by its number of seconds. A new request is taken only when the
// microprogram is back in its idle step; a finished response waits in an
// output register and does not hold up the next word, though the response
// after it stays in its final step until that register has been read.
// ----------------------------------------------------------------------------
module sliding_window_byte_rate_meter
  import swbrm_pkg::*;
#(
  parameter int unsigned WINDOW_SECONDS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  swbrm_req_if.sink   req_i,
  swbrm_rsp_if.source rsp_o
);

  // Count width holds the window size itself; index width addresses a bucket
  // of the ring, whose depth is a power of two no smaller than the window.
  localparam int unsigned CW = $clog2(WINDOW_SECONDS + 1);
  localparam int unsigned IW = (WINDOW_SECONDS > 1) ? $clog2(WINDOW_SECONDS) : 1;
  localparam int unsigned DEPTH = 2 ** IW;
  localparam logic [31:0]   WIN32 = 32'(WINDOW_SECONDS);
  localparam logic [CW-1:0] WINC  = CW'(WINDOW_SECONDS);

  // Sequencer.
  step_e  step_q, step_d;
  ucode_t uc;
  logic   jump;
  logic   in_acc;

  // Captured word.
  logic        kind_q;
  logic [31:0] cur_q;
  logic [31:0] bytes_q;

  // Window state.
  logic [31:0] begin_q;
  logic [31:0] end_q;
  logic [63:0] total_q;

  // Working registers.
  logic [IW-1:0] ci;
  logic [IW-1:0] ptr_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] gap_q;
  logic [CW-1:0] size_q;
  logic          restart_q;
  logic [31:0]   wbeg_q;
  logic [31:0]   wend_q;
  logic [63:0]   sum_q;
  logic          pend_q;
  logic [31:0]   rate_q;

  // Bucket store.
  logic [63:0]   mem_q [DEPTH];
  logic [63:0]   rd_q;
  logic [IW-1:0] rd_addr;
  logic [63:0]   cur_val;

  // Output register.
  logic        out_vld_q;
  logic [31:0] out_rate_q;
  logic [63:0] out_total_q;
  logic        out_full;
  logic        emit_fire;

  // Divider.
  div_ctl_t      div_ctl;
  logic [63:0]   div_dvd;
  logic [CW-1:0] div_dsr;
  logic          div_busy;
  logic [63:0]   div_quo;

  // Shared arithmetic.
  logic [31:0]   nxt;
  logic [31:0]   gap32;
  logic          restart;
  logic [31:0]   wb0;
  logic          empty;
  logic [CW-1:0] back_off;
  logic [IW-1:0] back_idx;
  logic [31:0]   dq32;
  logic [31:0]   span32;

  assign uc       = ucode(step_q);
  assign in_acc   = req_i.valid && req_i.ready;
  assign req_i.ready = (uc.op == OP_LOAD);

  assign out_full  = out_vld_q && !rsp_o.ready;
  assign emit_fire = (uc.op == OP_EMIT) && !out_full;

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.rate_bps    = out_rate_q;
  assign rsp_o.total_bytes = out_total_q;

  // Time of the word plus one; cur_q never exceeds 2^32-2, so it fits.
  assign nxt     = cur_q + 32'd1;
  assign gap32   = nxt - end_q;
  assign restart = (end_q == '0) || (nxt < end_q) || (gap32 > WIN32);
  assign wb0     = (nxt > WIN32) ? (nxt - WIN32) : 32'd0;
  assign empty   = (wend_q <= wbeg_q);
  assign dq32    = cur_q - wbeg_q;
  assign span32  = wend_q - wbeg_q;

  // Bucket index of the current second.
  assign ci = cur_q[IW-1:0];

  // Step back from the current bucket index by an offset below the window;
  // the ring depth is a power of two, so the index simply wraps.
  always_comb begin
    back_off = (uc.op == OP_ADD_SET) ? (gap_q - 1'b1) : dq32[CW-1:0];
    back_idx = ci - back_off[IW-1:0];
  end

  always_comb begin
    div_ctl.start = (uc.op == OP_DIV_GO);
    div_dvd       = sum_q;
    div_dsr       = size_q;
  end

  swbrm_div #(
    .DW (CW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (div_ctl),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dsr),
    .busy_o      (div_busy),
    .quotient_o  (div_quo)
  );

  // Next step: the control word's condition picks between its two targets.
  always_comb begin
    unique case (uc.jc)
      JC_NONE:     jump = 1'b0;
      JC_NO_IN:    jump = !in_acc;
      JC_DIV_BUSY: jump = div_busy;
      JC_QUERY:    jump = (kind_q == KIND_QUERY);
      JC_CNT_NZ:   jump = (cnt_q != '0);
      JC_EMPTY:    jump = empty;
      JC_OUT_FULL: jump = out_full;
      default:     jump = 1'b0;
    endcase
    step_d = jump ? uc.jt : uc.nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // Captured request; the last second value is folded onto the one below
  // so that one past it still fits in 32 bits.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q  <= req_i.kind;
      cur_q   <= (req_i.time_s == 32'hFFFF_FFFF) ? 32'hFFFF_FFFE : req_i.time_s;
      bytes_q <= req_i.byte_count;
    end
  end

  // Window bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_q <= '0;
      end_q   <= '0;
      total_q <= '0;
    end else begin
      if (uc.op == OP_ADD_SET) begin
        end_q <= nxt;
        if (restart_q) begin
          begin_q <= cur_q;
        end else if ((nxt > WIN32) && ((nxt - WIN32) > begin_q)) begin
          begin_q <= nxt - WIN32;
        end
      end
      if (uc.op == OP_WR_CUR) begin
        total_q <= total_q + {32'd0, bytes_q};
      end
    end
  end

  // Ring pointer and loop count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= (uc.op == OP_SUM) && (cnt_q != '0);
      if (uc.op == OP_ADD_SET) begin
        cnt_q <= restart_q ? '0 : gap_q;
        ptr_q <= back_idx;
      end else if ((uc.op == OP_Q_SET) && !empty) begin
        cnt_q <= span32[CW-1:0];
        ptr_q <= back_idx;
      end else if (((uc.op == OP_CLEAR) || (uc.op == OP_SUM)) && (cnt_q != '0)) begin
        cnt_q <= cnt_q - 1'b1;
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  // Payload working registers.
  always_ff @(posedge clk_i) begin
    if (uc.op == OP_ADD_CHK) begin
      restart_q <= restart;
      gap_q     <= gap32[CW-1:0];
    end
    if (uc.op == OP_Q_WIN) begin
      wend_q <= (nxt < end_q) ? nxt : end_q;
      wbeg_q <= (wb0 < begin_q) ? begin_q : wb0;
    end
    if (uc.op == OP_Q_SET) begin
      size_q <= span32[CW-1:0];
    end
    if (uc.op == OP_Q_SET) begin
      sum_q <= '0;
    end else if (pend_q) begin
      sum_q <= sum_q + rd_q;
    end
    if ((uc.op == OP_Q_SET) && empty) begin
      rate_q <= '0;
    end else if (uc.op == OP_DIV_TAKE) begin
      rate_q <= div_quo[31:0];
    end
  end

  // Bucket store: one read port with registered data, one write port.
  // Skipped seconds are zeroed as the window advances. After a restart only
  // the current second lies in the window, so its old contents are ignored;
  // every later second is zeroed on its way in.
  assign rd_addr = (uc.op == OP_RD_CUR) ? ci : ptr_q;
  assign cur_val = restart_q ? 64'd0 : rd_q;

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
    if ((uc.op == OP_CLEAR) && (cnt_q != '0)) begin
      mem_q[ptr_q] <= 64'd0;
    end else if (uc.op == OP_WR_CUR) begin
      mem_q[ci] <= cur_val + {32'd0, bytes_q};
    end
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit_fire) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_rate_q  <= rate_q;
      out_total_q <= total_q;
    end
  end

`ifndef SYNTHESIS
  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.start |-> !div_busy)
    else $error("divider started while busy");

  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (end_q != '0) |-> (begin_q < end_q))
    else $error("window begin is not below its end");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= WINC)
    else $error("loop count larger than the window");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (step_q == S_BR))
    else $error("accepted word did not start the microprogram");
`endif

endmodule

/* tb/sv/sliding_window_byte_rate_meter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window byte rate meter: self-checking testbench
// Directed and random add and query words go in, and every rate word that
// comes back is checked against a behavioural ring of per-second buckets.
// ----------------------------------------------------------------------------
// Add words are booked into a local copy of the bucket ring the moment the
// meter accepts them. Query words push the rate and running total that they
// should produce onto a queue, and the checker pops one expectation for each
// rate word taken from the response channel. The sender works in bursts with
// idle gaps between them, and the receiver applies back-pressure of its own.
// ----------------------------------------------------------------------------
module sliding_window_byte_rate_meter_tb
  import swbrm_pkg::*;
();

  localparam int unsigned WINDOW      = 16;
  localparam int unsigned ITEM_TARGET = 1750;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned MAX_PRINTED  = 40;

  typedef struct packed {
    logic [31:0] rate;
    logic [63:0] total;
  } rate_word_t;

  logic clk_i;
  logic rst_ni;

  swbrm_req_if req_if ();
  swbrm_rsp_if rsp_if ();

  sliding_window_byte_rate_meter #(
    .WINDOW_SECONDS(WINDOW)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Local copy of the meter's state.
  logic [63:0] bucket [WINDOW];
  logic [31:0] first_second;   // oldest second that still holds valid data
  logic [31:0] end_second;     // one past the newest second, zero when empty
  logic [63:0] running_total;

  rate_word_t  pending_rates[$];

  int unsigned burst_left;
  int unsigned words_sent;
  int unsigned adds_sent;
  int unsigned queries_sent;
  int unsigned restarts;
  int unsigned rates_checked;
  int unsigned mismatches;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Behavioural model of the bucket ring
  // --------------------------------------------------------------------------

  // The very last second is folded onto the one before it, so that one past
  // the newest second always fits in 32 bits.
  function automatic logic [31:0] clamp_second(logic [31:0] t);
    return (t == 32'hFFFF_FFFF) ? 32'hFFFF_FFFE : t;
  endfunction

  function automatic void book_bytes(logic [31:0] t, logic [31:0] n);
    logic [63:0] cur;
    logic [63:0] nxt;
    logic [63:0] fin;
    cur = {32'd0, clamp_second(t)};
    nxt = cur + 64'd1;
    fin = {32'd0, end_second};
    // An empty ring, time running backwards or a leap past the whole window
    // all throw the history away and start again at this second.
    if (fin == 64'd0 || nxt < fin || (nxt - fin) > WINDOW) begin
      foreach (bucket[i]) bucket[i] = '0;
      first_second = cur[31:0];
      fin = nxt;
      restarts++;
    end
    // Seconds that were skipped over hold no traffic.
    while (fin < nxt) begin
      bucket[fin % WINDOW] = '0;
      fin++;
    end
    end_second = fin[31:0];
    if (fin > WINDOW && (fin - WINDOW) > {32'd0, first_second}) begin
      first_second = fin[31:0] - WINDOW;
    end
    running_total += {32'd0, n};
    bucket[cur % WINDOW] += {32'd0, n};
  endfunction

  // Mean bytes per second over the valid seconds of the window ending at t.
  function automatic logic [31:0] window_rate(logic [31:0] t);
    logic [63:0] wend;
    logic [63:0] wbeg;
    logic [63:0] sum;
    logic [63:0] mean;
    wend = {32'd0, clamp_second(t)} + 64'd1;
    wbeg = (wend > WINDOW) ? wend - WINDOW : 64'd0;
    sum  = '0;
    if (wbeg < {32'd0, first_second}) wbeg = {32'd0, first_second};
    if (wend > {32'd0, end_second}) wend = {32'd0, end_second};
    if (wend <= wbeg) begin
      return 32'd0;
    end
    for (logic [63:0] s = wbeg; s < wend; s++) begin
      sum += bucket[s % WINDOW];
    end
    mean = sum / (wend - wbeg);
    return mean[31:0];
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Drives one word and waits for it to be taken. It must be called at a
  // rising edge. A new burst always begins with idle time on the channel, so
  // valid is never lowered and raised again within the same time step.
  task automatic send_word(input logic kind, input logic [31:0] t,
                           input logic [31:0] n);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    req_if.valid      <= 1'b1;
    req_if.kind       <= kind;
    req_if.time_s     <= t;
    req_if.byte_count <= n;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    // The word was accepted at this edge.
    if (kind == KIND_ADD) begin
      book_bytes(t, n);
      adds_sent++;
    end else begin
      pending_rates.push_back('{rate: window_rate(t), total: running_total});
      queries_sent++;
    end
    words_sent++;
    burst_left--;
    if (burst_left == 0) req_if.valid <= 1'b0;
  endtask

  // Closes the current burst, so that no word is left on the channel.
  task automatic close_burst();
    if (burst_left != 0) begin
      req_if.valid <= 1'b0;
      burst_left = 0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Response side
  // --------------------------------------------------------------------------

  // The receiver alternates short stall patterns with long stretches of
  // steady readiness. Each value of ready is held over a clock edge.
  initial begin
    int unsigned mode;
    rsp_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      rsp_if.ready <= 1'b1;
      if (mode == 0) begin
        repeat ($urandom_range(50, 300)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h",
               $time, what, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_rates
    rate_word_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rates.size() == 0) begin
        report_mismatch("unexpected rate word", {32'd0, rsp_if.rate_bps}, '0);
      end else begin
        want = pending_rates.pop_front();
        if (rsp_if.rate_bps !== want.rate) begin
          report_mismatch("rate_bps", {32'd0, rsp_if.rate_bps}, {32'd0, want.rate});
        end
        if (rsp_if.total_bytes !== want.total) begin
          report_mismatch("total_bytes", rsp_if.total_bytes, want.total);
        end
        rates_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Queries on an empty ring give a zero rate and a zero total.
  task automatic test_query_before_add();
    send_word(KIND_QUERY, 32'd0, 32'hFFFF_FFFF);
    send_word(KIND_QUERY, 32'hFFFF_FFFF, 32'd0);
  endtask

  // Words in the same second pile up in one bucket; three full-scale words
  // in one second push the mean past 32 bits, so the rate wraps.
  task automatic test_same_second_wrap();
    repeat (3) send_word(KIND_ADD, 32'd100, 32'hFFFF_FFFF);
    send_word(KIND_QUERY, 32'd100, 32'd0);
  endtask

  // Skipped seconds are cleared, a gap of exactly one window still slides,
  // and queries earlier than the recorded data see only the overlap.
  task automatic test_window_slide();
    send_word(KIND_ADD,   32'd105, 32'd1000);
    send_word(KIND_QUERY, 32'd50,  32'd0);
    send_word(KIND_QUERY, 32'd90,  32'd0);
    send_word(KIND_QUERY, 32'd102, 32'd0);
    send_word(KIND_QUERY, 32'd110, 32'd0);
    send_word(KIND_ADD,   32'd121, 32'd77);
    send_word(KIND_QUERY, 32'd121, 32'd0);
  endtask

  // A leap past the window and a step back in time both restart the ring.
  task automatic test_restart();
    send_word(KIND_ADD,   32'd200, 32'd5000);
    send_word(KIND_ADD,   32'd150, 32'd3);
    send_word(KIND_QUERY, 32'd160, 32'd0);
  endtask

  // The lowest second, and the highest one, which is folded onto its
  // neighbour.
  task automatic test_time_extremes();
    send_word(KIND_ADD,   32'd0,         32'd0);
    send_word(KIND_QUERY, 32'd0,         32'd0);
    send_word(KIND_ADD,   32'hFFFF_FFFF, 32'd5);
    send_word(KIND_ADD,   32'hFFFF_FFFE, 32'd7);
    send_word(KIND_QUERY, 32'hFFFF_FFFF, 32'd0);
    send_word(KIND_QUERY, 32'hFFFF_FFFE, 32'd0);
    send_word(KIND_ADD,   32'hFFFF_FFF0, 32'h8000_0000);
    send_word(KIND_QUERY, 32'hFFFF_FFFF, 32'd0);
  endtask

  function automatic logic [31:0] shift_second(logic [31:0] t, int delta);
    longint v;
    v = longint'(t) + delta;
    if (v < 0) v = 0;
    if (v > 64'h0000_0000_FFFF_FFFF) v = 64'h0000_0000_FFFF_FFFF;
    return v[31:0];
  endfunction

  // Sessions of traffic that mostly moves forward a second or two at a time,
  // so that the window fills and slides, with queries around the present,
  // occasional leaps and steps back, and some words at random seconds.
  task automatic test_random_traffic();
    logic [31:0] now;
    logic [31:0] t;
    logic [31:0] n;
    int unsigned steps;
    int unsigned pick;
    int          delta;
    while (words_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       now = $urandom_range(0, 40);
        1:       now = 32'hFFFF_FFFF - $urandom_range(0, 40);
        default: now = $urandom;
      endcase
      steps = $urandom_range(10, 60);
      for (int unsigned k = 0; k < steps && words_sent < ITEM_TARGET; k++) begin
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
          0:       n = '0;
          1:       n = 32'hFFFF_FFFF;
          2, 3, 4: n = $urandom_range(0, 5000);
          default: n = $urandom;
        endcase
        if (pick < 55) begin
          case ($urandom_range(0, 9))
            0:          delta = $urandom_range(6, 20);
            1, 2, 3:    delta = $urandom_range(2, 5);
            default:    delta = $urandom_range(0, 1);
          endcase
          now = shift_second(now, delta);
          send_word(KIND_ADD, now, n);
        end else if (pick < 90) begin
          delta = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 40) - 20 : 0;
          send_word(KIND_QUERY, shift_second(now, delta), n);
        end else if (pick < 95) begin
          now = shift_second(now, -$urandom_range(1, 20));
          send_word(KIND_ADD, now, n);
        end else begin
          t = $urandom;
          send_word($urandom_range(0, 1) ? KIND_QUERY : KIND_ADD, t, n);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    req_if.valid      = 1'b0;
    req_if.kind       = KIND_ADD;
    req_if.time_s     = '0;
    req_if.byte_count = '0;
    rst_ni            = 1'b0;
    foreach (bucket[i]) bucket[i] = '0;
    first_second  = '0;
    end_second    = '0;
    running_total = '0;
    burst_left    = 0;
    words_sent    = 0;
    adds_sent     = 0;
    queries_sent  = 0;
    restarts      = 0;
    rates_checked = 0;
    mismatches    = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_query_before_add();
    test_same_second_wrap();
    test_window_slide();
    test_restart();
    test_time_extremes();
    test_random_traffic();
    close_burst();

    while (pending_rates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d add words and %0d query words; the ring restarted %0d times.",
             adds_sent, queries_sent, restarts);
    $display("Checked %0d rate words, %0d mismatches.", rates_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // A correct run needs well under 3 ms of simulated time.
  initial begin
    #10_000_000;
    $display("Timed out with %0d rate words outstanding.", pending_rates.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
src/swbrm_pkg.sv
src/swbrm_if.sv
src/swbrm_div.sv
src/sliding_window_byte_rate_meter.sv
tb/sv/sliding_window_byte_rate_meter_tb.sv
